// ===== rtl/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpc_pkg: shared definitions of the lidar polar to cartesian converter
// Widths, fixed-point constants, register codes, pipeline word types and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package lpc_pkg;

  // Design constants.
  localparam int SCAN_POINTS   = 2048;
  localparam int CORDIC_STAGES = 18;
  localparam int MAX_STAGES    = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int STAGE_W       = $clog2(MAX_STAGES);

  // Angles in units of 2^-20 rad.
  localparam int PI_Q      = 3294199;
  localparam int TWO_PI_Q  = 6588397;
  localparam int HALF_PI_Q = 1647099;
  localparam int GAIN_INV_Q16 = 39797;
  localparam int OUT_LIMIT    = 65535;
  localparam int ROUND_HALF   = 32768;

  // Field widths.
  localparam int IDX_W   = 11;
  localparam int RNG_W   = 16;
  localparam int START_W = 23;
  localparam int STEP_W  = 16;
  localparam int OUT_W   = 17;

  // Internal widths.
  localparam int PROD_W  = IDX_W + STEP_W;
  localparam int ANG_W   = 28;
  localparam int X0_W    = 32;
  localparam int XY_W    = 35;
  localparam int Z_W     = 27;
  localparam int ATAN_W  = 24;
  localparam int RED_STEPS = 5;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_START = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_FIRST_INDEX = 3'd2,
    REG_LAST_INDEX  = 3'd3,
    REG_MIN_RANGE   = 3'd4,
    REG_MAX_RANGE   = 3'd5
  } lpc_reg_e;

  localparam logic [START_W-1:0] RST_ANGLE_START = START_W'(-3294199);
  localparam logic [STEP_W-1:0]  RST_ANGLE_STEP  = STEP_W'(4575);
  localparam logic [IDX_W-1:0]   RST_FIRST_INDEX = IDX_W'(0);
  localparam logic [IDX_W-1:0]   RST_LAST_INDEX  = IDX_W'(2047);
  localparam logic [RNG_W-1:0]   RST_MIN_RANGE   = RNG_W'(250);
  localparam logic [RNG_W-1:0]   RST_MAX_RANGE   = RNG_W'(7695);

  typedef struct packed {
    logic [START_W-1:0] angle_start;
    logic [STEP_W-1:0]  angle_step;
    logic [IDX_W-1:0]   first_index;
    logic [IDX_W-1:0]   last_index;
    logic [RNG_W-1:0]   min_range_mm;
    logic [RNG_W-1:0]   max_range_mm;
  } lpc_cfg_t;

  // Word of the angle reduction pipeline.
  typedef struct packed {
    logic             keep;
    logic             last;
    logic [ANG_W-1:0] ang;
    logic [X0_W-1:0]  x0;
  } lpc_red_t;

  // Word handed from one CORDIC cell to the next.
  typedef struct packed {
    logic                   keep;
    logic                   last;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } lpc_rot_t;

  // atan(2^-i) in units of 2^-24 rad, rounded to nearest.
  localparam logic [ATAN_W-1:0] ATAN_TAB [MAX_STAGES] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
    24'd1047214,  24'd524117,  24'd262123,  24'd131069,
    24'd65536,    24'd32768,   24'd16384,   24'd8192,
    24'd4096,     24'd2048,    24'd1024,    24'd512,
    24'd256,      24'd128,     24'd64,      24'd32,
    24'd16,       24'd8,       24'd4,       24'd2
  };

endpackage

// ===== rtl/lpc_if.sv =====
// ----------------------------------------------------------------------------
// lpc_if: handshake channels of the lidar polar to cartesian converter
// Sample input channel, point output channel and register write channel.
// ----------------------------------------------------------------------------
interface lpc_in_if import lpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] beam_index;
  logic [RNG_W-1:0] range_mm;
  logic             scan_last;

  modport source (output valid, output beam_index, output range_mm, output scan_last,
                  input ready);
  modport sink   (input valid, input beam_index, input range_mm, input scan_last,
                  output ready);
endinterface

interface lpc_out_if import lpc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    point_valid;
  logic signed [OUT_W-1:0] x_mm;
  logic signed [OUT_W-1:0] y_mm;
  logic                    scan_end;

  modport source (output valid, output point_valid, output x_mm, output y_mm,
                  output scan_end, input ready);
  modport sink   (input valid, input point_valid, input x_mm, input y_mm,
                  input scan_end, output ready);
endinterface

interface lpc_cfg_if import lpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lpc_prep.sv =====
// ----------------------------------------------------------------------------
// lpc_prep: gating and angle reduction front end
// Checks the index window and range gate, forms the beam angle, reduces it
// modulo two pi by compare and subtract steps and folds it into the CORDIC
// range, producing the start word of the cell chain.
// ----------------------------------------------------------------------------
module lpc_prep import lpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lpc_cfg_t         cfg_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [IDX_W-1:0] beam_index_i,
  input  logic [RNG_W-1:0] range_mm_i,
  input  logic             scan_last_i,
  output logic             valid_o,
  input  logic             ready_i,
  output lpc_rot_t         data_o
);

  localparam int NP = RED_STEPS + 3;

  logic [NP-1:0] v_q;
  logic [NP:0]   adv;
  logic [NP-1:0] v_in;

  lpc_red_t s0_q;
  lpc_red_t red_q [RED_STEPS+1];
  lpc_rot_t fold_q;

  assign adv[NP] = ready_i;
  for (genvar k = 0; k < NP; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end

  assign v_in    = {v_q[NP-2:0], valid_i};
  assign ready_o = adv[0];
  assign valid_o = v_q[NP-1];
  assign data_o  = fold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NP; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // Gate check, angle product and scaled start vector.
  logic keep_d;
  assign keep_d = (beam_index_i >= cfg_i.first_index) &&
                  (beam_index_i <= cfg_i.last_index) &&
                  (32'(beam_index_i) < SCAN_POINTS) &&
                  (range_mm_i >= cfg_i.min_range_mm) &&
                  (range_mm_i <= cfg_i.max_range_mm);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_q.keep <= keep_d;
      s0_q.last <= scan_last_i;
      s0_q.ang  <= ANG_W'(PROD_W'(beam_index_i) * PROD_W'(cfg_i.angle_step));
      s0_q.x0   <= X0_W'(range_mm_i) * X0_W'(GAIN_INV_Q16);
    end
  end

  // Add the start angle plus two pi, which keeps the sum non-negative.
  logic [ANG_W-1:0] start_ext;
  assign start_ext = {{(ANG_W-START_W){cfg_i.angle_start[START_W-1]}}, cfg_i.angle_start};

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      red_q[0].keep <= s0_q.keep;
      red_q[0].last <= s0_q.last;
      red_q[0].x0   <= s0_q.x0;
      red_q[0].ang  <= s0_q.ang + start_ext + ANG_W'(TWO_PI_Q);
    end
  end

  // Restoring reduction by 16, 8, 4, 2 and 1 times two pi.
  for (genvar j = 1; j <= RED_STEPS; j++) begin : g_red
    localparam logic [ANG_W-1:0] MOD_M = ANG_W'(TWO_PI_Q) << (RED_STEPS - j);
    always_ff @(posedge clk_i) begin
      if (adv[j+1]) begin
        red_q[j].keep <= red_q[j-1].keep;
        red_q[j].last <= red_q[j-1].last;
        red_q[j].x0   <= red_q[j-1].x0;
        red_q[j].ang  <= (red_q[j-1].ang >= MOD_M) ? red_q[j-1].ang - MOD_M
                                                    : red_q[j-1].ang;
      end
    end
  end

  // Fold into the right half plane and build the start vector.
  logic [ANG_W-1:0]        r_w;
  logic signed [ANG_W-1:0] a_d;
  logic                    neg_d;
  logic signed [XY_W-1:0]  x_ext;

  assign r_w   = red_q[RED_STEPS].ang;
  assign x_ext = XY_W'(red_q[RED_STEPS].x0);

  always_comb begin
    priority if (r_w <= ANG_W'(HALF_PI_Q)) begin
      a_d   = signed'(r_w);
      neg_d = 1'b0;
    end else if (r_w <= ANG_W'(PI_Q)) begin
      a_d   = signed'(r_w - ANG_W'(PI_Q));
      neg_d = 1'b1;
    end else if (r_w < ANG_W'(TWO_PI_Q - HALF_PI_Q)) begin
      a_d   = signed'(r_w - ANG_W'(TWO_PI_Q - PI_Q));
      neg_d = 1'b1;
    end else begin
      a_d   = signed'(r_w - ANG_W'(TWO_PI_Q));
      neg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NP-1]) begin
      fold_q.keep <= red_q[RED_STEPS].keep;
      fold_q.last <= red_q[RED_STEPS].last;
      fold_q.x    <= neg_d ? -x_ext : x_ext;
      fold_q.y    <= '0;
      fold_q.z    <= Z_W'(a_d <<< 4);
    end
  end

endmodule

// ===== rtl/lpc_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// lpc_cordic_cell: one CORDIC rotation cell
// Rotates the word by plus or minus atan(2^-i), the direction set by the sign
// of the residual angle, and registers it for the next cell.
// ----------------------------------------------------------------------------
module lpc_cordic_cell import lpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [STAGE_W-1:0] stage_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  lpc_rot_t           data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output lpc_rot_t           data_o
);

  logic                   v_q;
  lpc_rot_t               data_q;
  lpc_rot_t               data_d;
  logic signed [XY_W-1:0] x_w;
  logic signed [XY_W-1:0] y_w;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  z_w;
  logic signed [Z_W-1:0]  atan_w;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign data_o  = data_q;

  assign x_w    = data_i.x;
  assign y_w    = data_i.y;
  assign z_w    = data_i.z;
  assign dx     = y_w >>> stage_i;
  assign dy     = x_w >>> stage_i;
  assign atan_w = signed'(Z_W'(ATAN_TAB[stage_i]));

  always_comb begin
    data_d = data_i;
    if (!z_w[Z_W-1]) begin
      data_d.x = x_w - dx;
      data_d.y = y_w + dy;
      data_d.z = z_w - atan_w;
    end else begin
      data_d.x = x_w + dx;
      data_d.y = y_w - dy;
      data_d.z = z_w + atan_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/lidar_polar_to_cartesian.sv =====
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian: lidar range sample to cartesian point converter
// Gates each sample by beam index window and range limits, reduces the beam
// angle and rotates the range by a pipelined CORDIC chain into x and y in mm.
// ----------------------------------------------------------------------------
//
//   channel   role    word
//   sample_i  sink    beam_index, range_mm, scan_last
//   point_o   source  point_valid, x_mm, y_mm, scan_end
//   cfg_i     sink    index, data (register write, always ready)
//
// One word is accepted per cycle unless the pipeline is backed up, and every
// sample gives exactly one point. Words pass the front end registers, the
// register of each CORDIC cell and the output register; the 18 cells set the depth.
// Each stage holds its word while the next is full, so bubbles close up and
// input is taken as long as any stage is free.
// Reset empties the pipeline and loads the register defaults.
//
module lidar_polar_to_cartesian import lpc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  lpc_in_if.sink     sample_i,
  lpc_out_if.source  point_o,
  lpc_cfg_if.sink    cfg_i
);

  localparam int RW = XY_W - 16;

  lpc_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_start  <= RST_ANGLE_START;
      cfg_q.angle_step   <= RST_ANGLE_STEP;
      cfg_q.first_index  <= RST_FIRST_INDEX;
      cfg_q.last_index   <= RST_LAST_INDEX;
      cfg_q.min_range_mm <= RST_MIN_RANGE;
      cfg_q.max_range_mm <= RST_MAX_RANGE;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (lpc_reg_e'(cfg_i.index))
        REG_ANGLE_START: cfg_q.angle_start  <= cfg_i.data[START_W-1:0];
        REG_ANGLE_STEP:  cfg_q.angle_step   <= cfg_i.data[STEP_W-1:0];
        REG_FIRST_INDEX: cfg_q.first_index  <= cfg_i.data[IDX_W-1:0];
        REG_LAST_INDEX:  cfg_q.last_index   <= cfg_i.data[IDX_W-1:0];
        REG_MIN_RANGE:   cfg_q.min_range_mm <= cfg_i.data[RNG_W-1:0];
        REG_MAX_RANGE:   cfg_q.max_range_mm <= cfg_i.data[RNG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic     rot_v [NUM_STAGES+1];
  logic     rot_r [NUM_STAGES+1];
  lpc_rot_t rot_d [NUM_STAGES+1];

  lpc_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .valid_i      (sample_i.valid),
    .ready_o      (sample_i.ready),
    .beam_index_i (sample_i.beam_index),
    .range_mm_i   (sample_i.range_mm),
    .scan_last_i  (sample_i.scan_last),
    .valid_o      (rot_v[0]),
    .ready_i      (rot_r[0]),
    .data_o       (rot_d[0])
  );

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
    lpc_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (STAGE_W'(g)),
      .valid_i (rot_v[g]),
      .ready_o (rot_r[g]),
      .data_i  (rot_d[g]),
      .valid_o (rot_v[g+1]),
      .ready_i (rot_r[g+1]),
      .data_o  (rot_d[g+1])
    );
  end

  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] t;
    logic signed [RW-1:0]   r;
    t = v + XY_W'(ROUND_HALF);
    r = signed'(t[XY_W-1:16]);
    if (r > signed'(RW'(OUT_LIMIT))) begin
      return OUT_W'(OUT_LIMIT);
    end
    if (r < signed'(RW'(-OUT_LIMIT))) begin
      return OUT_W'(-OUT_LIMIT);
    end
    return r[OUT_W-1:0];
  endfunction

  logic                    out_v_q;
  logic                    pv_q;
  logic signed [OUT_W-1:0] x_q;
  logic signed [OUT_W-1:0] y_q;
  logic                    end_q;
  lpc_rot_t                fin;

  assign fin                = rot_d[NUM_STAGES];
  assign rot_r[NUM_STAGES]  = !out_v_q || point_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rot_r[NUM_STAGES]) begin
      out_v_q <= rot_v[NUM_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rot_r[NUM_STAGES]) begin
      pv_q  <= fin.keep;
      x_q   <= fin.keep ? round_sat(fin.x) : '0;
      y_q   <= fin.keep ? round_sat(fin.y) : '0;
      end_q <= fin.last;
    end
  end

  assign point_o.valid       = out_v_q;
  assign point_o.point_valid = pv_q;
  assign point_o.x_mm        = x_q;
  assign point_o.y_mm        = y_q;
  assign point_o.scan_end    = end_q;

  // A rejected sample leaves the block with zero coordinates.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_o.valid && !point_o.point_valid) |-> (point_o.x_mm == '0 && point_o.y_mm == '0))
    else $error("rejected point carries nonzero coordinates");

  // Saturation never lets the most negative code through.
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_o.valid |-> (point_o.x_mm != OUT_W'(-OUT_LIMIT - 1) &&
                       point_o.y_mm != OUT_W'(-OUT_LIMIT - 1)))
    else $error("coordinate outside the saturation limits");

  // Input is refused only when the whole pipeline is backed up behind the output.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> (point_o.valid && !point_o.ready))
    else $error("input refused while the output is not stalled");

endmodule
